// File: rtl/core/io_port_interval_timer_unit_defines.svh
// Assertion macros used by the interval timer RTL.
`ifndef IO_PORT_INTERVAL_TIMER_UNIT_DEFINES_SVH
`define IO_PORT_INTERVAL_TIMER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define IOTMR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define IOTMR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/iotmr_pkg.sv
// Types, constants and helper functions of the I/O port and interval timer.
`default_nettype none

package iotmr_pkg;

    // Request codes carried by each item.
    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_TICK  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    // Port register select in the low two address bits.
    typedef enum logic [1:0] {
        PORT_A_DATA = 2'd0,
        PORT_A_DDR  = 2'd1,
        PORT_B_DATA = 2'd2,
        PORT_B_DDR  = 2'd3
    } t_port_reg;

    // Address bit positions.
    localparam int unsigned ADDR_TMR_SEL  = 2;  // 1: timer and edge block
    localparam int unsigned ADDR_FLAG_SEL = 0;  // read: 1 flag register, 0 timer
    localparam int unsigned ADDR_IRQ_EN   = 3;  // timer interrupt enable
    localparam int unsigned ADDR_TMR_LOAD = 4;  // write: 1 timer load, 0 edge control
    localparam int unsigned ADDR_EDGE_EN  = 0;  // edge interrupt enable
    localparam int unsigned ADDR_EDGE_POL = 1;  // edge polarity, 1 rising

    localparam int unsigned PRESCALE_W = 11;
    localparam logic [7:0]  TIMER_RESET = 8'hFF;

    // One decoded item as handed to the register blocks.
    typedef struct packed {
        logic       valid;
        t_req       req;
        logic [4:0] addr;
        logic [7:0] data;
    } t_op;

    // Prescaler period for a select code: 1, 8, 64 or 1024.
    function automatic logic [PRESCALE_W-1:0] prescale_div(input logic [1:0] sel);
        logic [PRESCALE_W-1:0] d;
        case (sel)
            2'd0:    d = 11'd1;
            2'd1:    d = 11'd8;
            2'd2:    d = 11'd64;
            default: d = 11'd1024;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/iotmr_ifs.sv
// Handshake interfaces for the request and response channels.
`default_nettype none

interface iotmr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [4:0] reg_addr;
    logic [7:0] write_data;
    logic [7:0] pa_pins;
    logic [7:0] pb_pins;

    modport source (output valid, req_type, reg_addr, write_data, pa_pins, pb_pins,
                    input ready);
    modport sink   (input valid, req_type, reg_addr, write_data, pa_pins, pb_pins,
                    output ready);
endinterface

interface iotmr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       irq;
    logic [7:0] port_a_drive;
    logic [7:0] port_b_drive;
    logic       port_b_strobe;

    modport source (output valid, read_data, irq, port_a_drive, port_b_drive,
                    port_b_strobe, input ready);
    modport sink   (input valid, read_data, irq, port_a_drive, port_b_drive,
                    port_b_strobe, output ready);
endinterface

`default_nettype wire

// File: rtl/core/iotmr_ports.sv
// Port A and port B output latches, direction registers and port read mux.
`default_nettype none

module iotmr_ports (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire iotmr_pkg::t_op i_op,
    input  wire logic [7:0]    i_pa_pins,
    input  wire logic [7:0]    i_pb_pins,
    output logic [7:0]         o_rdata,
    output logic [7:0]         o_pa_drive,
    output logic [7:0]         o_pb_drive,
    output logic               o_pb_strobe
);
    import iotmr_pkg::*;

    logic [7:0] r_pa_latch, n_pa_latch;
    logic [7:0] r_dir_a,    n_dir_a;
    logic [7:0] r_pb_latch, n_pb_latch;
    logic [7:0] r_dir_b,    n_dir_b;
    t_port_reg  sel;
    logic       port_acc;

    assign sel      = t_port_reg'(i_op.addr[1:0]);
    assign port_acc = !i_op.addr[ADDR_TMR_SEL];

    // Register writes and the read mux; pins show where the direction bit is 0.
    always_comb begin
        n_pa_latch  = r_pa_latch;
        n_dir_a     = r_dir_a;
        n_pb_latch  = r_pb_latch;
        n_dir_b     = r_dir_b;
        o_rdata     = 8'd0;
        o_pb_strobe = 1'b0;
        if (port_acc && i_op.req == REQ_WRITE) begin
            case (sel)
                PORT_A_DATA: n_pa_latch = i_op.data;
                PORT_A_DDR:  n_dir_a    = i_op.data;
                PORT_B_DATA: begin
                    n_pb_latch  = i_op.data;
                    o_pb_strobe = 1'b1;
                end
                PORT_B_DDR:  n_dir_b    = i_op.data;
                default: ;
            endcase
        end
        if (port_acc && i_op.req == REQ_READ) begin
            case (sel)
                PORT_A_DATA: o_rdata = (i_pa_pins & ~r_dir_a) | (r_pa_latch & r_dir_a);
                PORT_A_DDR:  o_rdata = r_dir_a;
                PORT_B_DATA: o_rdata = (i_pb_pins & ~r_dir_b) | (r_pb_latch & r_dir_b);
                PORT_B_DDR:  o_rdata = r_dir_b;
                default:     o_rdata = 8'd0;
            endcase
        end
    end

    assign o_pa_drive = n_pa_latch;
    assign o_pb_drive = n_pb_latch;

    // State is updated only when the item is executed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pa_latch <= 8'd0;
            r_dir_a    <= 8'd0;
            r_pb_latch <= 8'd0;
            r_dir_b    <= 8'd0;
        end else if (i_op.valid) begin
            r_pa_latch <= n_pa_latch;
            r_dir_a    <= n_dir_a;
            r_pb_latch <= n_pb_latch;
            r_dir_b    <= n_dir_b;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/iotmr_timer.sv
// Interval timer with prescaler, port A top-bit edge detector and interrupt logic.
`default_nettype none
`include "io_port_interval_timer_unit_defines.svh"

module iotmr_timer (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire iotmr_pkg::t_op i_op,
    input  wire logic          i_pa7,
    output logic [7:0]         o_rdata,
    output logic               o_irq
);
    import iotmr_pkg::*;

    logic [7:0]            r_timer_value, n_timer_value;
    logic [1:0]            r_prescale_sel, n_prescale_sel;
    logic [PRESCALE_W-1:0] r_prescale_rem, n_prescale_rem;
    logic                  r_timer_ie,    n_timer_ie;
    logic                  r_timer_flag,  n_timer_flag;
    logic                  r_timer_done,  n_timer_done;
    logic                  r_edge_ie,     n_edge_ie;
    logic                  r_edge_rising, n_edge_rising;
    logic                  r_edge_flag,   n_edge_flag;
    logic                  r_edge_prev,   n_edge_prev;
    logic                  edge_set;
    logic                  tmr_acc;
    logic                  load_op;
    logic                  flag_rd_op;

    assign tmr_acc  = i_op.addr[ADDR_TMR_SEL];
    assign edge_set = (i_pa7 != r_edge_prev) && (i_pa7 == r_edge_rising);

    // Executed timer loads and flag register reads.
    assign load_op    = i_op.valid && i_op.req == REQ_WRITE && tmr_acc
                        && i_op.addr[ADDR_TMR_LOAD];
    assign flag_rd_op = i_op.valid && i_op.req == REQ_READ && tmr_acc
                        && i_op.addr[ADDR_FLAG_SEL];

    // Edge sampling first, then the register access or the tick.
    always_comb begin
        n_timer_value  = r_timer_value;
        n_prescale_sel = r_prescale_sel;
        n_prescale_rem = r_prescale_rem;
        n_timer_ie     = r_timer_ie;
        n_timer_flag   = r_timer_flag;
        n_timer_done   = r_timer_done;
        n_edge_ie      = r_edge_ie;
        n_edge_rising  = r_edge_rising;
        n_edge_prev    = i_pa7;
        n_edge_flag    = r_edge_flag | edge_set;
        o_rdata        = 8'd0;
        case (i_op.req)
            REQ_READ: begin
                if (tmr_acc) begin
                    if (i_op.addr[ADDR_FLAG_SEL]) begin
                        o_rdata     = {r_timer_flag, n_edge_flag, 6'd0};
                        n_edge_flag = 1'b0;
                    end else begin
                        o_rdata      = r_timer_value;
                        n_timer_ie   = i_op.addr[ADDR_IRQ_EN];
                        n_timer_flag = 1'b0;
                    end
                end
            end
            REQ_WRITE: begin
                if (tmr_acc) begin
                    if (i_op.addr[ADDR_TMR_LOAD]) begin
                        n_prescale_sel = i_op.addr[1:0];
                        n_prescale_rem = prescale_div(i_op.addr[1:0]);
                        n_timer_value  = i_op.data;
                        n_timer_ie     = i_op.addr[ADDR_IRQ_EN];
                        n_timer_flag   = 1'b0;
                        n_timer_done   = 1'b0;
                    end else begin
                        n_edge_ie     = i_op.addr[ADDR_EDGE_EN];
                        n_edge_rising = i_op.addr[ADDR_EDGE_POL];
                    end
                end
            end
            REQ_TICK: begin
                // After expiry the timer runs at the undivided rate and wraps.
                if (r_timer_done) begin
                    n_timer_value = r_timer_value - 8'd1;
                end else if (r_prescale_rem > 11'd1) begin
                    n_prescale_rem = r_prescale_rem - 11'd1;
                end else begin
                    n_prescale_rem = prescale_div(r_prescale_sel);
                    if (r_timer_value == 8'd0) begin
                        n_timer_flag  = 1'b1;
                        n_timer_done  = 1'b1;
                        n_timer_value = TIMER_RESET;
                    end else begin
                        n_timer_value = r_timer_value - 8'd1;
                    end
                end
            end
            default: ;
        endcase
        o_irq = (n_timer_flag & n_timer_ie) | (n_edge_flag & n_edge_ie);
    end

    // State is updated only when the item is executed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer_value  <= TIMER_RESET;
            r_prescale_sel <= 2'd0;
            r_prescale_rem <= 11'd1;
            r_timer_ie     <= 1'b0;
            r_timer_flag   <= 1'b0;
            r_timer_done   <= 1'b0;
            r_edge_ie      <= 1'b0;
            r_edge_rising  <= 1'b0;
            r_edge_flag    <= 1'b0;
            r_edge_prev    <= 1'b0;
        end else if (i_op.valid) begin
            r_timer_value  <= n_timer_value;
            r_prescale_sel <= n_prescale_sel;
            r_prescale_rem <= n_prescale_rem;
            r_timer_ie     <= n_timer_ie;
            r_timer_flag   <= n_timer_flag;
            r_timer_done   <= n_timer_done;
            r_edge_ie      <= n_edge_ie;
            r_edge_rising  <= n_edge_rising;
            r_edge_flag    <= n_edge_flag;
            r_edge_prev    <= n_edge_prev;
        end
    end

    // The timer flag is only ever set together with expiry.
    `IOTMR_ASSERT_NOW(a_flag_implies_done, r_timer_flag, r_timer_done, "timer flag without expiry")
    // The prescaler count never reaches zero.
    `IOTMR_ASSERT_NOW(a_prescale_nonzero, 1'b1, r_prescale_rem != 11'd0, "prescaler count is zero")
    // A timer load restarts the count.
    `IOTMR_ASSERT_NEXT(a_load_restart, load_op, !r_timer_done && !r_timer_flag, "load kept expiry")
    // Reading the flag register clears the edge flag.
    `IOTMR_ASSERT_NEXT(a_flag_rd_clr_edge, flag_rd_op, !r_edge_flag, "flag read kept edge flag")

endmodule

`default_nettype wire

// File: rtl/core/io_port_interval_timer_unit.sv
// Top level of the I/O port and interval timer unit.
// Usage:
//   i_req carries one item per handshake: a register read, a register write
//   or one timer clock tick, together with the current port A and B pin levels.
//   o_rsp returns exactly one item per request: read data (zero for writes and
//   ticks), the interrupt line, both port output latches and the port B write
//   strobe, all as they stand after the request.
//   Each item passes two register stages: the accepting edge loads the input
//   register, and the edge at which the item executes updates the registers
//   and loads the response register. Throughput is one item per cycle while
//   the receiver keeps o_rsp.ready high.
//   When the receiver holds o_rsp.ready low the response register holds its
//   item; the input register still takes one more item only if it is empty,
//   and i_req.ready is then low until the response is taken.
//   Synchronous active-low reset clears both pipeline valids and puts the
//   ports, direction registers, timer (0xFF, divide by one) and flags in
//   their reset state; i_req.ready is low during reset and the block takes
//   items as soon as i_rst_n is high.
`default_nettype none

module io_port_interval_timer_unit (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    iotmr_in_if.sink    i_req,
    iotmr_out_if.source o_rsp
);
    import iotmr_pkg::*;

    logic       r_in_valid;
    logic [1:0] r_in_req;
    logic [4:0] r_in_addr;
    logic [7:0] r_in_data;
    logic [7:0] r_in_pa;
    logic [7:0] r_in_pb;

    logic       r_out_valid;
    logic [7:0] r_out_rdata;
    logic       r_out_irq;
    logic [7:0] r_out_pa;
    logic [7:0] r_out_pb;
    logic       r_out_strobe;

    logic       in_move;
    t_op        op;
    logic [7:0] port_rdata;
    logic [7:0] tmr_rdata;
    logic       tmr_irq;
    logic [7:0] pa_drive;
    logic [7:0] pb_drive;
    logic       pb_strobe;

    // The held item executes whenever the response register can take its result.
    assign in_move     = !r_out_valid || o_rsp.ready;
    assign i_req.ready = i_rst_n && (!r_in_valid || in_move);

    assign op.valid = r_in_valid && in_move;
    assign op.req   = t_req'(r_in_req);
    assign op.addr  = r_in_addr;
    assign op.data  = r_in_data;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_req  <= i_req.req_type;
            r_in_addr <= i_req.reg_addr;
            r_in_data <= i_req.write_data;
            r_in_pa   <= i_req.pa_pins;
            r_in_pb   <= i_req.pb_pins;
        end
    end

    iotmr_ports u_ports (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (op),
        .i_pa_pins   (r_in_pa),
        .i_pb_pins   (r_in_pb),
        .o_rdata     (port_rdata),
        .o_pa_drive  (pa_drive),
        .o_pb_drive  (pb_drive),
        .o_pb_strobe (pb_strobe)
    );

    iotmr_timer u_timer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (op),
        .i_pa7   (r_in_pa[7]),
        .o_rdata (tmr_rdata),
        .o_irq   (tmr_irq)
    );

    // Response register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_move) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (op.valid) begin
            r_out_rdata  <= port_rdata | tmr_rdata;
            r_out_irq    <= tmr_irq;
            r_out_pa     <= pa_drive;
            r_out_pb     <= pb_drive;
            r_out_strobe <= pb_strobe;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.read_data     = r_out_rdata;
    assign o_rsp.irq           = r_out_irq;
    assign o_rsp.port_a_drive  = r_out_pa;
    assign o_rsp.port_b_drive  = r_out_pb;
    assign o_rsp.port_b_strobe = r_out_strobe;

endmodule

`default_nettype wire

// File: tb/tb_io_port_interval_timer_unit.sv
// Self-checking testbench for the I/O port and interval timer unit.
`timescale 1ns / 100ps

module tb_io_port_interval_timer_unit;
    import iotmr_pkg::*;

    localparam int RANDOM_ITEMS = 1825;
    localparam int QUIET_ITEMS  = 300;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AFTER   = 150;
    localparam int STALL_LIMIT  = 3000;
    localparam int MAX_PRINTS   = 40;

    // One request item and one response item as seen on the channels.
    typedef struct packed {
        t_req       req;
        logic [4:0] addr;
        logic [7:0] data;
        logic [7:0] pa;
        logic [7:0] pb;
    } req_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq;
        logic [7:0] pa_drive;
        logic [7:0] pb_drive;
        logic       pb_strobe;
    } rsp_item_t;

    // Shadow of the port and timer registers, and the responses they imply.
    class timer_port_scoreboard;
        logic [7:0]  latch_a, ddr_a, latch_b, ddr_b;
        logic [7:0]  count;
        logic [1:0]  div_sel;
        logic [10:0] div_left;
        logic        tmr_ie, tmr_flag, tmr_expired;
        logic        edge_ie, edge_pol_rise, edge_flag, pa7_last;
        rsp_item_t   expected_q[$];
        int          mismatches;
        int          n_checked;

        function new();
            latch_a = 8'h00; ddr_a = 8'h00; latch_b = 8'h00; ddr_b = 8'h00;
            count = TIMER_RESET;
            div_sel = 2'd0;
            div_left = 11'd1;
            tmr_ie = 1'b0; tmr_flag = 1'b0; tmr_expired = 1'b0;
            edge_ie = 1'b0; edge_pol_rise = 1'b0; edge_flag = 1'b0; pa7_last = 1'b0;
            mismatches = 0;
            n_checked = 0;
        endfunction

        function logic [10:0] period_of(logic [1:0] sel);
            case (sel)
                2'd0:    return 11'd1;
                2'd1:    return 11'd8;
                2'd2:    return 11'd64;
                default: return 11'd1024;
            endcase
        endfunction

        // Work out the response to an accepted request and queue it.
        function void note_request(req_item_t it);
            rsp_item_t r;
            logic      lvl;
            r = '0;
            lvl = it.pa[7];

            // The pin edge is sampled before the request itself acts.
            if (lvl != pa7_last) begin
                if ((edge_pol_rise && lvl) || (!edge_pol_rise && !lvl))
                    edge_flag = 1'b1;
                pa7_last = lvl;
            end

            case (it.req)
                REQ_READ: begin
                    if (!it.addr[ADDR_TMR_SEL]) begin
                        case (t_port_reg'(it.addr[1:0]))
                            PORT_A_DATA: r.read_data = (it.pa & ~ddr_a) | (latch_a & ddr_a);
                            PORT_A_DDR:  r.read_data = ddr_a;
                            PORT_B_DATA: r.read_data = (it.pb & ~ddr_b) | (latch_b & ddr_b);
                            default:     r.read_data = ddr_b;
                        endcase
                    end else if (it.addr[ADDR_FLAG_SEL]) begin
                        r.read_data = {tmr_flag, edge_flag, 6'b0};
                        edge_flag = 1'b0;
                    end else begin
                        r.read_data = count;
                        tmr_ie = it.addr[ADDR_IRQ_EN];
                        tmr_flag = 1'b0;
                    end
                end
                REQ_WRITE: begin
                    if (!it.addr[ADDR_TMR_SEL]) begin
                        case (t_port_reg'(it.addr[1:0]))
                            PORT_A_DATA: latch_a = it.data;
                            PORT_A_DDR:  ddr_a = it.data;
                            PORT_B_DATA: begin
                                latch_b = it.data;
                                r.pb_strobe = 1'b1;
                            end
                            default:     ddr_b = it.data;
                        endcase
                    end else if (it.addr[ADDR_TMR_LOAD]) begin
                        div_sel = it.addr[1:0];
                        div_left = period_of(div_sel);
                        count = it.data;
                        tmr_ie = it.addr[ADDR_IRQ_EN];
                        tmr_flag = 1'b0;
                        tmr_expired = 1'b0;
                    end else begin
                        edge_ie = it.addr[ADDR_EDGE_EN];
                        edge_pol_rise = it.addr[ADDR_EDGE_POL];
                    end
                end
                REQ_TICK: begin
                    // After expiry the timer runs at full rate and wraps.
                    if (tmr_expired) begin
                        count = count - 8'd1;
                    end else if (div_left > 11'd1) begin
                        div_left = div_left - 11'd1;
                    end else begin
                        div_left = period_of(div_sel);
                        if (count == 8'd0) begin
                            tmr_flag = 1'b1;
                            tmr_expired = 1'b1;
                            count = 8'hFF;
                        end else begin
                            count = count - 8'd1;
                        end
                    end
                end
                default: ;
            endcase

            r.irq = (tmr_flag && tmr_ie) || (edge_flag && edge_ie);
            r.pa_drive = latch_a;
            r.pb_drive = latch_b;
            expected_q.push_back(r);
        endfunction

        task report(input string what, input int got, input int want);
            mismatches++;
            if (mismatches <= MAX_PRINTS)
                $display("result %0d: %s mismatch, got %0h expected %0h",
                         n_checked, what, got, want);
        endtask

        // Compare a response, field by field, with the oldest expectation.
        task check_response(input rsp_item_t got);
            rsp_item_t want;
            if (expected_q.size() == 0) begin
                report("unrequested result", 1, 0);
            end else begin
                want = expected_q.pop_front();
                if (got.read_data !== want.read_data)
                    report("read_data", got.read_data, want.read_data);
                if (got.irq !== want.irq)
                    report("irq", got.irq, want.irq);
                if (got.pa_drive !== want.pa_drive)
                    report("port_a_drive", got.pa_drive, want.pa_drive);
                if (got.pb_drive !== want.pb_drive)
                    report("port_b_drive", got.pb_drive, want.pb_drive);
                if (got.pb_strobe !== want.pb_strobe)
                    report("port_b_strobe", got.pb_strobe, want.pb_strobe);
            end
            n_checked++;
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    iotmr_in_if  req_if();
    iotmr_out_if rsp_if();

    io_port_interval_timer_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    timer_port_scoreboard sb = new();

    int   n_accepted = 0;
    int   n_random   = 0;
    logic quiet      = 1'b0;
    logic pa7_level  = 1'b0;

    always #1 i_clk = ~i_clk;

    // Offer one item, with an occasional idle burst first, and wait for acceptance.
    task automatic send_item(input req_item_t it);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 7) == 0)
            gap = $urandom_range(1, 15);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.req_type   <= it.req;
        req_if.reg_addr   <= it.addr;
        req_if.write_data <= it.data;
        req_if.pa_pins    <= it.pa;
        req_if.pb_pins    <= it.pb;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        sb.note_request(it);
        n_accepted++;
    endtask

    task automatic direct(input t_req r, input logic [4:0] a, input logic [7:0] d,
                          input logic [7:0] pa, input logic [7:0] pb);
        send_item('{req: r, addr: a, data: d, pa: pa, pb: pb});
    endtask

    // Random pins, with port A bit 7 toggling now and then to make edges.
    task automatic issue(input t_req r, input logic [4:0] a, input logic [7:0] d);
        if ($urandom_range(0, 3) == 0)
            pa7_level = ~pa7_level;
        if (r != REQ_NONE)
            n_random++;
        if (n_random >= RANDOM_ITEMS - QUIET_ITEMS)
            quiet = 1'b1;
        send_item('{req: r, addr: a, data: d, pa: {pa7_level, 7'($urandom)},
                    pb: 8'($urandom)});
    endtask

    // Load the timer and clock it, mostly far enough to expire.
    task automatic timer_run(input logic long_run);
        int         pick;
        int         ticks;
        logic [1:0] sel;
        logic [7:0] value;
        pick = $urandom_range(0, 15);
        sel = (pick < 8) ? 2'd0 : (pick < 13) ? 2'd1 : (pick < 15) ? 2'd2 : 2'd3;
        case (sel)
            2'd0: begin
                value = ($urandom_range(0, 4) == 0) ? 8'($urandom)
                                                    : 8'($urandom_range(0, 12));
                ticks = value + 1 + $urandom_range(0, 20);
            end
            2'd1: begin
                value = 8'($urandom_range(0, 6));
                ticks = (value + 1) * 8 + $urandom_range(0, 12);
            end
            2'd2: begin
                value = 8'($urandom_range(0, 1));
                ticks = (value + 1) * 64 + $urandom_range(0, 8);
            end
            default: begin
                value = 8'($urandom_range(0, 3));
                ticks = $urandom_range(0, 40);
            end
        endcase
        // One slow run goes through a full divide-by-1024 expiry.
        if (long_run) begin
            sel = 2'd3;
            value = 8'd0;
            ticks = 1030;
        end
        issue(REQ_WRITE, {1'b1, 1'($urandom), 1'b1, sel}, value);
        for (int k = 0; k < ticks; k++) begin
            if (!long_run && $urandom_range(0, 5) == 0)
                issue(REQ_READ, {2'($urandom), 1'b1, 2'($urandom)}, 8'($urandom));
            issue(REQ_TICK, 5'($urandom), 8'($urandom));
        end
        issue(REQ_READ, {2'($urandom), 1'b1, 2'($urandom)}, 8'($urandom));
    endtask

    // Receiver: random stalls, one long hold-off, then always ready.
    initial begin
        logic held;
        held = 1'b0;
        rsp_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!held && n_accepted >= HOLD_AFTER) begin
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                held = 1'b1;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
        end
    end

    // Response monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready)
            sb.check_response('{read_data: rsp_if.read_data, irq: rsp_if.irq,
                                pa_drive: rsp_if.port_a_drive,
                                pb_drive: rsp_if.port_b_drive,
                                pb_strobe: rsp_if.port_b_strobe});
    end

    // Watchdog on cycles in which neither channel moves an item.
    initial begin
        int stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                stalled = 0;
            else
                stalled++;
        end
        $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("FAIL io_port_interval_timer_unit");
        $finish;
    end

    initial begin
        int  choice;
        logic long_done;
        long_done = 1'b0;
        i_rst_n           <= 1'b0;
        req_if.valid      <= 1'b0;
        req_if.req_type   <= REQ_NONE;
        req_if.reg_addr   <= 5'd0;
        req_if.write_data <= 8'd0;
        req_if.pa_pins    <= 8'd0;
        req_if.pb_pins    <= 8'd0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: port reads through the direction masks.
        direct(REQ_READ,  {3'b000, PORT_A_DATA}, 8'h00, 8'h7F, 8'h00);
        direct(REQ_WRITE, {3'b000, PORT_A_DDR},  8'hF0, 8'h00, 8'h00);
        direct(REQ_WRITE, {3'b000, PORT_A_DATA}, 8'hA5, 8'h00, 8'h00);
        direct(REQ_READ,  {3'b000, PORT_A_DATA}, 8'hFF, 8'h0F, 8'hFF);
        direct(REQ_WRITE, {3'b000, PORT_B_DDR},  8'hFF, 8'h00, 8'h00);
        direct(REQ_WRITE, {3'b000, PORT_B_DATA}, 8'h3C, 8'h00, 8'h00);
        direct(REQ_READ,  {3'b000, PORT_B_DATA}, 8'h00, 8'h00, 8'h00);
        direct(REQ_READ,  {3'b000, PORT_A_DDR},  8'h00, 8'h00, 8'h00);
        direct(REQ_READ,  {3'b000, PORT_B_DDR},  8'h00, 8'h00, 8'h00);
        direct(REQ_WRITE, {3'b000, PORT_B_DDR},  8'h00, 8'h00, 8'h00);
        direct(REQ_READ,  {3'b111, PORT_B_DATA}, 8'h00, 8'h00, 8'hFF);
        // Edge detector: a rising edge, then a falling edge seen by the
        // flag read of the same item.
        direct(REQ_WRITE, 5'b00111, 8'h00, 8'h00, 8'h00);
        direct(REQ_TICK,  5'b00000, 8'h00, 8'h80, 8'h00);
        direct(REQ_READ,  5'b00101, 8'h00, 8'h80, 8'h00);
        direct(REQ_WRITE, 5'b00101, 8'h00, 8'h80, 8'h00);
        direct(REQ_READ,  5'b00101, 8'h00, 8'h00, 8'h00);
        // Timer: expiry from zero, the wrap at full rate, and a read
        // that clears the flag but keeps the timer free-running.
        direct(REQ_WRITE, 5'b11100, 8'h00, 8'h00, 8'h00);
        direct(REQ_TICK,  5'b11111, 8'hFF, 8'h00, 8'h00);
        direct(REQ_TICK,  5'b00000, 8'h00, 8'h00, 8'h00);
        direct(REQ_READ,  5'b00100, 8'h00, 8'h00, 8'h00);
        direct(REQ_READ,  5'b00101, 8'h00, 8'h00, 8'h00);
        direct(REQ_TICK,  5'b00000, 8'h00, 8'h00, 8'h00);
        direct(REQ_WRITE, 5'b11111, 8'hFF, 8'h00, 8'h00);
        direct(REQ_READ,  5'b01100, 8'h00, 8'h00, 8'h00);
        // The unused request code only samples the edge pin.
        direct(REQ_NONE,  5'b11111, 8'hFF, 8'hFF, 8'hFF);

        // Random part: mostly well-formed sequences, some noise.
        while (n_random < RANDOM_ITEMS) begin
            choice = $urandom_range(0, 9);
            if (!long_done && n_random > 400) begin
                timer_run(1'b1);
                long_done = 1'b1;
            end else if (choice <= 3) begin
                timer_run(1'b0);
            end else if (choice <= 5) begin
                repeat ($urandom_range(2, 8))
                    issue($urandom_range(0, 1) ? REQ_READ : REQ_WRITE,
                          {2'($urandom), 1'b0, 2'($urandom)}, 8'($urandom));
            end else if (choice <= 7) begin
                issue(REQ_WRITE, {1'b0, 1'($urandom), 1'b1, 2'($urandom)}, 8'($urandom));
                repeat ($urandom_range(3, 10))
                    issue($urandom_range(0, 1) ? REQ_TICK : REQ_READ,
                          {2'($urandom), 1'b1, 1'($urandom), 1'b1}, 8'($urandom));
            end else if (choice == 8) begin
                repeat ($urandom_range(1, 6))
                    issue(t_req'($urandom_range(0, 3)), 5'($urandom), 8'($urandom));
            end else begin
                issue(REQ_READ, 5'($urandom), 8'($urandom));
            end
        end
        req_if.valid <= 1'b0;

        // Drain, then allow for the pipeline latency.
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("PASS io_port_interval_timer_unit");
        end else begin
            $display("FAIL io_port_interval_timer_unit");
        end
        $finish;
    end

endmodule
